// ===== sv/srq_pkg.sv =====
// ============================================================================
// srq_pkg: shared definitions for the searchable reversible queue
// Holds the queue depth, derived widths, operation codes, status codes,
// the transfer payload types and the ring slot arithmetic.
// ============================================================================
package srq_pkg;

    localparam int DEPTH  = 16;
    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    // Depth in the widths where it is compared or added.
    localparam logic [SLOT_W:0]   DEPTH_V  = (SLOT_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0]  DEPTH_C  = CNT_W'(DEPTH);
    localparam logic [SLOT_W-1:0] DEPTH_M1 = SLOT_W'(DEPTH - 1);

    // Operation codes carried in the kind field.
    localparam logic [2:0] KIND_ENQ        = 3'd0;
    localparam logic [2:0] KIND_DEQ        = 3'd1;
    localparam logic [2:0] KIND_READ_FRONT = 3'd2;
    localparam logic [2:0] KIND_READ_BACK  = 3'd3;
    localparam logic [2:0] KIND_FIND       = 3'd4;
    localparam logic [2:0] KIND_REVERSE    = 3'd5;
    localparam logic [2:0] KIND_SIZE       = 3'd6;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_NOMATCH = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]               kind;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [3:0]               position;
        logic [4:0]               occupancy;
        t_status                  status;
    } t_out_item;

    // Adds two ring slots and wraps the sum back into the ring.
    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                   input logic [SLOT_W-1:0] b);
        logic [SLOT_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= DEPTH_V) begin
            sum = sum - DEPTH_V;
        end
        return sum[SLOT_W-1:0];
    endfunction

endpackage

// ===== sv/srq_ram.sv =====
// ============================================================================
// srq_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered and holds its
// value in cycles without a read.
// ============================================================================
module srq_ram #(
    parameter int DATA_W  = 32,
    parameter int ADDR_W  = 4,
    parameter int DEPTH_N = 16
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH_N];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/searchable_reversible_queue_unit.sv =====
// ============================================================================
// searchable_reversible_queue_unit: bounded FIFO with search and reverse
// Ring buffer queue of signed words with enqueue, dequeue, end reads,
// search from the front, order reversal and occupancy report.
// ============================================================================
// The unit handles one operation at a time. An input transfer is taken only
// while the controller is idle; for every operation except a search of a
// non-empty queue, the execute state then writes the result into the output
// register once that register is free, and the next input transfer can be
// taken when the controller is back in idle. A search walks the stored
// entries from the front through the single read port of the entry RAM, one
// entry per cycle, and stops at the first match or after the last entry. A
// finished result sits in the output register until it is taken, and a new
// input transfer is accepted while it waits; a result that finds the output
// register still full stalls in place. Reversal only flips a direction flag,
// so both ends of the queue swap roles with no data moved. Full and empty
// conditions are reported in the status field and leave the queue untouched.
// The entry RAM is not cleared at reset; only written entries reach a result.
// ============================================================================
module searchable_reversible_queue_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  srq_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output srq_pkg::t_out_item o_out_item
);

    import srq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FIND
    } t_state;

    // Control state.
    t_state            r_state, n_state;
    logic [SLOT_W-1:0] r_head,  n_head;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_rev,   n_rev;
    logic              r_out_valid, n_out_valid;

    // Payload held for the operation in flight and the result.
    logic [2:0]               r_kind,  n_kind;
    logic signed [DATA_W-1:0] r_value, n_value;
    logic [SLOT_W-1:0]        r_idx,   n_idx;
    t_out_item                r_out,   n_out;

    // RAM ports.
    logic                     w_we;
    logic [SLOT_W-1:0]        w_waddr;
    logic signed [DATA_W-1:0] w_wdata;
    logic                     w_re;
    logic [SLOT_W-1:0]        w_raddr;
    logic signed [DATA_W-1:0] w_rdata;

    logic w_out_free;
    logic w_match;
    logic w_last;
    logic w_empty;

    srq_ram #(
        .DATA_W (DATA_W),
        .ADDR_W (SLOT_W),
        .DEPTH_N(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // Maps a position counted from the front to its ring slot. In normal
    // order the front sits at the head slot; reversed, it sits at the slot
    // of the last stored entry and positions count down from there.
    function automatic logic [SLOT_W-1:0] f_slot(input logic [SLOT_W-1:0] logical,
                                                 input logic [SLOT_W-1:0] head,
                                                 input logic [CNT_W-1:0]  count,
                                                 input logic              rev);
        logic [SLOT_W-1:0] off;
        if (rev) begin
            off = SLOT_W'(count - CNT_W'(1) - CNT_W'(logical));
        end else begin
            off = logical;
        end
        return slot_add(head, off);
    endfunction

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // The output register can take a result when it is empty or being drained.
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_empty    = (r_count == '0);
    assign w_match    = (w_rdata == r_value);
    assign w_last     = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_rev       = r_rev;
        n_out_valid = r_out_valid && !i_out_ready;
        n_kind      = r_kind;
        n_value     = r_value;
        n_idx       = r_idx;
        n_out       = r_out;
        w_we        = 1'b0;
        w_waddr     = slot_add(r_head, SLOT_W'(r_count));
        w_wdata     = r_value;
        w_re        = 1'b0;
        w_raddr     = f_slot('0, r_head, r_count, r_rev);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    // Start the RAM read right away so that the end reads and
                    // the first search compare see their data next cycle.
                    n_kind  = i_in_item.kind;
                    n_value = i_in_item.value;
                    n_idx   = '0;
                    w_re    = 1'b1;
                    if (i_in_item.kind == KIND_READ_BACK) begin
                        w_raddr = f_slot(SLOT_W'(r_count - CNT_W'(1)),
                                         r_head, r_count, r_rev);
                    end
                    if (i_in_item.kind == KIND_FIND && !w_empty) begin
                        n_state = S_FIND;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end

            S_EXEC: begin
                if (w_out_free) begin
                    n_out.data     = '0;
                    n_out.position = '0;
                    n_out.status   = ST_OK;
                    case (r_kind) inside
                        KIND_ENQ: begin
                            if (r_count == DEPTH_C) begin
                                n_out.status = ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                n_count = r_count + CNT_W'(1);
                                if (r_rev) begin
                                    // Reversed, the back is below the head.
                                    n_head  = slot_add(r_head, DEPTH_M1);
                                    w_waddr = n_head;
                                end
                            end
                        end
                        KIND_DEQ: begin
                            if (w_empty) begin
                                n_out.status = ST_EMPTY;
                            end else begin
                                n_count = r_count - CNT_W'(1);
                                if (!r_rev) begin
                                    n_head = slot_add(r_head, SLOT_W'(1));
                                end
                            end
                        end
                        KIND_READ_FRONT, KIND_READ_BACK: begin
                            if (w_empty) begin
                                n_out.status = ST_EMPTY;
                            end else begin
                                n_out.data = w_rdata;
                            end
                        end
                        KIND_REVERSE: begin
                            if (w_empty) begin
                                n_out.status = ST_EMPTY;
                            end else begin
                                n_rev = !r_rev;
                            end
                        end
                        KIND_FIND, KIND_SIZE: begin
                            // A search only lands here on an empty queue.
                            if (w_empty) begin
                                n_out.status = ST_EMPTY;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_out.occupancy = 5'(n_count);
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end

            S_FIND: begin
                if (w_match || w_last) begin
                    // The read data holds while the result waits for room.
                    if (w_out_free) begin
                        n_out.data      = '0;
                        n_out.position  = w_match ? 4'(r_idx) : 4'd0;
                        n_out.occupancy = 5'(r_count);
                        n_out.status    = w_match ? ST_OK : ST_NOMATCH;
                        n_out_valid     = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else begin
                    n_idx   = r_idx + SLOT_W'(1);
                    w_re    = 1'b1;
                    w_raddr = f_slot(n_idx, r_head, r_count, r_rev);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_rev       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_rev       <= n_rev;
            r_out_valid <= n_out_valid;
        end
        r_kind  <= n_kind;
        r_value <= n_value;
        r_idx   <= n_idx;
        r_out   <= n_out;
    end

    // The occupancy never goes past the ring size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count exceeds the queue depth");

    // The search index stays inside the stored entries.
    a_find_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIND) |-> (CNT_W'(r_idx) < r_count))
        else $error("search index runs past the stored entries");

    // The RAM is written only when an enqueue completes.
    a_write_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_EXEC && r_kind == KIND_ENQ && w_out_free))
        else $error("RAM write outside an enqueue completion");

    // Taking an input transfer makes the unit busy, so input ready drops.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken again before the operation finished");

endmodule
